// ===== rtl/ffla_pkg.sv =====
package ffla_pkg;

  localparam int ADDR_W = 20;
  localparam int LEN_W  = 21;

  localparam logic [LEN_W:0] SPACE_BYTES = {2'b01, {ADDR_W{1'b0}}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
  localparam logic [1:0] STATUS_HEAP_FULL  = 2'd2;
  localparam logic [1:0] STATUS_ZERO_SIZE  = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] block_offset;
    logic [LEN_W-1:0]  block_size;
  } ffla_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_offset;
    logic              reused_free;
    logic [1:0]        status;
  } ffla_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
  } ffla_ext_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WRITE_A,
    S_WRITE_B,
    S_WRITE_C,
    S_REPLY
  } ffla_state_t;

endpackage

// ===== rtl/ffla_ram.sv =====
module ffla_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/first_fit_free_list_allocator.sv =====
// A request that carries a zero size, or a free that runs past the address space, gives
// its result word in the cycle after acceptance; the next request is taken in the cycle
// after that. Any other request scans the whole free table through the single read port
// of the table memory, then passes S_DECIDE, S_WRITE_A, S_WRITE_B and S_WRITE_C before
// the result word in S_REPLY, and no new request is taken before S_IDLE. After reset the
// block clears the table, one entry a cycle, and holds busy high until that is done.
module first_fit_free_list_allocator
  import ffla_pkg::*;
#(
  parameter int FREE_ENTRIES = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ffla_req_t cmd,
  output logic      busy,
  output logic      done,
  output ffla_rsp_t result
);

  localparam int IW = $clog2(FREE_ENTRIES);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(FREE_ENTRIES - 1);
  localparam logic [CW-1:0] SCAN_END = CW'(FREE_ENTRIES);
  localparam int EW = $bits(ffla_ext_t);

  ffla_state_t state, state_next;
  logic [CW-1:0]    cnt;
  logic             rd_vld;
  logic [IW-1:0]    rd_idx;
  ffla_req_t        req;
  logic [LEN_W:0]   end_addr;
  logic [LEN_W-1:0] heap_end;
  ffla_rsp_t        rsp;

  logic              fit_found;
  logic [IW-1:0]     fit_idx;
  logic [ADDR_W-1:0] fit_start;
  logic [LEN_W-1:0]  fit_len;
  logic              nxt_found;
  logic [IW-1:0]     nxt_idx;
  logic [LEN_W-1:0]  nxt_len;
  logic              prv_found;
  logic [IW-1:0]     prv_idx;
  logic [ADDR_W-1:0] prv_start;
  logic [LEN_W-1:0]  prv_len;
  logic              inv_found;
  logic [IW-1:0]     inv_idx;

  logic      inv_a_en, inv_b_en, fin_en;
  logic [IW-1:0] fin_idx;
  ffla_ext_t fin_data;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  ffla_ext_t     ram_wdata;
  logic [EW-1:0] ram_rdata;
  ffla_ext_t     ext;

  logic           accept, immediate;
  logic [LEN_W:0] cmd_end;
  ffla_rsp_t      rsp_imm;

  logic              p_inv_a_en, p_inv_b_en, p_fin_en, p_grow;
  logic [IW-1:0]     p_fin_idx, slot;
  ffla_ext_t         p_fin_data;
  ffla_rsp_t         p_rsp;
  logic [LEN_W:0]    heap_sum;
  logic [ADDR_W-1:0] merged_off;
  logic [LEN_W-1:0]  merged_len;

  ffla_ram #(
    .WIDTH (EW),
    .DEPTH (FREE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign ext     = ffla_ext_t'(ram_rdata);
  assign busy    = (state != S_IDLE);
  assign done    = (state == S_REPLY);
  assign result  = rsp;
  assign accept  = start && (state == S_IDLE);
  assign cmd_end = {2'b00, cmd.block_offset} + {1'b0, cmd.block_size};
  assign immediate = (cmd.block_size == '0) ||
                     ((cmd.operation == OP_FREE) && (cmd_end > SPACE_BYTES));

  always_comb begin
    rsp_imm = '0;
    rsp_imm.status = (cmd.block_size == '0) ? STATUS_ZERO_SIZE : STATUS_HEAP_FULL;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (cnt == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = immediate ? S_REPLY : S_SCAN;
      end
      S_SCAN: begin
        if (cnt == SCAN_END) state_next = S_DECIDE;
      end
      S_DECIDE:  state_next = S_WRITE_A;
      S_WRITE_A: state_next = S_WRITE_B;
      S_WRITE_B: state_next = S_WRITE_C;
      S_WRITE_C: state_next = S_REPLY;
      S_REPLY:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[IW-1:0];
    ram_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_WRITE_A: begin
        ram_we    = inv_a_en;
        ram_waddr = nxt_idx;
      end
      S_WRITE_B: begin
        ram_we    = inv_b_en;
        ram_waddr = prv_idx;
      end
      S_WRITE_C: begin
        ram_we    = fin_en;
        ram_waddr = fin_idx;
        ram_wdata = fin_data;
      end
      S_IDLE, S_SCAN, S_DECIDE, S_REPLY: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    heap_sum   = {1'b0, heap_end} + {1'b0, req.block_size};
    merged_off = prv_found ? prv_start : req.block_offset;
    merged_len = req.block_size + (nxt_found ? nxt_len : '0) + (prv_found ? prv_len : '0);
    slot = inv_found ? inv_idx : (nxt_found ? nxt_idx : prv_idx);
    if (nxt_found && (nxt_idx < slot)) slot = nxt_idx;
    if (prv_found && (prv_idx < slot)) slot = prv_idx;

    p_inv_a_en = 1'b0;
    p_inv_b_en = 1'b0;
    p_fin_en   = 1'b0;
    p_fin_idx  = fit_idx;
    p_fin_data = '0;
    p_grow     = 1'b0;
    p_rsp      = '0;
    if (req.operation == OP_ALLOC) begin
      if (fit_found) begin
        p_rsp.result_offset = fit_start;
        p_rsp.reused_free   = 1'b1;
        p_rsp.status        = STATUS_OK;
        p_fin_en            = 1'b1;
        if (fit_len != req.block_size) begin
          p_fin_data.valid  = 1'b1;
          p_fin_data.start  = fit_start + req.block_size[ADDR_W-1:0];
          p_fin_data.length = fit_len - req.block_size;
        end
      end else if (heap_sum > SPACE_BYTES) begin
        p_rsp.status = STATUS_HEAP_FULL;
      end else begin
        p_rsp.result_offset = heap_end[ADDR_W-1:0];
        p_rsp.status        = STATUS_OK;
        p_grow              = 1'b1;
      end
    end else begin
      if (!nxt_found && !prv_found) begin
        if (!inv_found) begin
          p_rsp.status = STATUS_TABLE_FULL;
        end else begin
          p_rsp.result_offset = req.block_offset;
          p_fin_en            = 1'b1;
          p_fin_idx           = inv_idx;
          p_fin_data.valid    = 1'b1;
          p_fin_data.start    = req.block_offset;
          p_fin_data.length   = req.block_size;
        end
      end else begin
        p_rsp.result_offset = merged_off;
        p_inv_a_en          = nxt_found;
        p_inv_b_en          = prv_found;
        p_fin_en            = 1'b1;
        p_fin_idx           = slot;
        p_fin_data.valid    = 1'b1;
        p_fin_data.start    = merged_off;
        p_fin_data.length   = merged_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      rd_vld   <= 1'b0;
      heap_end <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN) && (cnt != SCAN_END);
      rd_idx <= cnt[IW-1:0];
      if (state == S_CLEAR || state == S_SCAN) begin
        cnt <= cnt + 1'b1;
      end else if (accept) begin
        cnt <= '0;
      end
      if (state == S_DECIDE && p_grow) begin
        heap_end <= heap_sum[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req       <= cmd;
      end_addr  <= cmd_end;
      fit_found <= 1'b0;
      nxt_found <= 1'b0;
      prv_found <= 1'b0;
      inv_found <= 1'b0;
      if (immediate) rsp <= rsp_imm;
    end else if (rd_vld) begin
      if (ext.valid && (ext.length >= req.block_size) &&
          (!fit_found || (ext.start < fit_start))) begin
        fit_found <= 1'b1;
        fit_idx   <= rd_idx;
        fit_start <= ext.start;
        fit_len   <= ext.length;
      end
      if (ext.valid && !nxt_found && ({2'b00, ext.start} == end_addr)) begin
        nxt_found <= 1'b1;
        nxt_idx   <= rd_idx;
        nxt_len   <= ext.length;
      end
      if (ext.valid && !prv_found &&
          (({2'b00, ext.start} + {1'b0, ext.length}) == {2'b00, req.block_offset})) begin
        prv_found <= 1'b1;
        prv_idx   <= rd_idx;
        prv_start <= ext.start;
        prv_len   <= ext.length;
      end
      if (!ext.valid && !inv_found) begin
        inv_found <= 1'b1;
        inv_idx   <= rd_idx;
      end
    end
    if (state == S_DECIDE) begin
      inv_a_en <= p_inv_a_en;
      inv_b_en <= p_inv_b_en;
      fin_en   <= p_fin_en;
      fin_idx  <= p_fin_idx;
      fin_data <= p_fin_data;
      rsp      <= p_rsp;
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import ffla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 32;

  typedef struct packed {
    ffla_req_t req;
    int        count;
    int        stride;
    logic      has_want;
    ffla_rsp_t want;
  } script_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [LEN_W-1:0]  length;
  } live_block_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  ffla_req_t cmd = '0;
  logic      busy;
  logic      done;
  ffla_rsp_t result;

  // Free extent table and heap end as the allocator should hold them.
  logic [ADDR_W-1:0] hole_start [ENTRIES];
  logic [LEN_W-1:0]  hole_len [ENTRIES];
  logic              hole_live [ENTRIES];
  logic [LEN_W:0]    heap_top;

  ffla_rsp_t   awaited_replies [$];
  live_block_t live_blocks [$];
  script_row_t script [$];
  int          errors = 0;
  int          burst_left = 0;

  first_fit_free_list_allocator #(
    .FREE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic ffla_rsp_t apply_request(ffla_req_t r);
    ffla_rsp_t         rsp;
    int                i;
    int                fit;
    int                nxt;
    int                prv;
    int                slot;
    logic [LEN_W+1:0]  span_end;
    logic [LEN_W+1:0]  span_len;
    logic [ADDR_W-1:0] span_off;
    rsp = '0;
    fit = -1;
    nxt = -1;
    prv = -1;
    slot = -1;
    if (r.block_size == '0) begin
      rsp.status = STATUS_ZERO_SIZE;
      return rsp;
    end
    if (r.operation == OP_ALLOC) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (hole_live[i] && hole_len[i] >= r.block_size &&
            (fit < 0 || hole_start[i] < hole_start[fit])) begin
          fit = i;
        end
      end
      if (fit >= 0) begin
        rsp.result_offset = hole_start[fit];
        rsp.reused_free = 1'b1;
        if (hole_len[fit] == r.block_size) begin
          hole_live[fit] = 1'b0;
        end else begin
          hole_start[fit] = hole_start[fit] + r.block_size[ADDR_W-1:0];
          hole_len[fit] = hole_len[fit] - r.block_size;
        end
      end else if (heap_top + r.block_size > SPACE_BYTES) begin
        rsp.status = STATUS_HEAP_FULL;
      end else begin
        rsp.result_offset = heap_top[ADDR_W-1:0];
        heap_top = heap_top + r.block_size;
      end
      return rsp;
    end
    span_end = {3'b000, r.block_offset} + {2'b00, r.block_size};
    if (span_end > {1'b0, SPACE_BYTES}) begin
      rsp.status = STATUS_HEAP_FULL;
      return rsp;
    end
    for (i = 0; i < ENTRIES; i++) begin
      if (hole_live[i] && nxt < 0 && {3'b000, hole_start[i]} == span_end) begin
        nxt = i;
      end
    end
    for (i = 0; i < ENTRIES; i++) begin
      if (hole_live[i] && i != nxt && prv < 0 &&
          ({3'b000, hole_start[i]} + {2'b00, hole_len[i]}) == {3'b000, r.block_offset}) begin
        prv = i;
      end
    end
    if (nxt < 0 && prv < 0) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (!hole_live[i] && slot < 0) begin
          slot = i;
        end
      end
      if (slot < 0) begin
        rsp.status = STATUS_TABLE_FULL;
        return rsp;
      end
    end
    span_off = r.block_offset;
    span_len = {2'b00, r.block_size};
    if (nxt >= 0) begin
      span_len = span_len + hole_len[nxt];
      hole_live[nxt] = 1'b0;
    end
    if (prv >= 0) begin
      span_off = hole_start[prv];
      span_len = span_len + hole_len[prv];
      hole_live[prv] = 1'b0;
    end
    if (slot < 0) begin
      for (i = 0; i < ENTRIES; i++) begin
        if (!hole_live[i] && slot < 0) begin
          slot = i;
        end
      end
    end
    hole_start[slot] = span_off;
    hole_len[slot] = span_len[LEN_W-1:0];
    hole_live[slot] = 1'b1;
    rsp.result_offset = span_off;
    return rsp;
  endfunction

  function automatic ffla_req_t draw_request();
    ffla_req_t   r;
    int          pick;
    int          k;
    int unsigned base;
    live_block_t blk;
    r.operation = OP_ALLOC;
    r.block_offset = ADDR_W'($urandom());
    r.block_size = LEN_W'(1);
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 85 && live_blocks.size() == 0) begin
      pick = 0;
    end
    if (pick < 45 && live_blocks.size() > 300) begin
      pick = 60;
    end
    if (pick < 45) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        r.block_size = LEN_W'($urandom_range(1, 64));
      end else if (k < 90) begin
        r.block_size = LEN_W'($urandom_range(65, 4096));
      end else if (k < 99) begin
        r.block_size = LEN_W'($urandom_range(4097, 65536));
      end else begin
        r.block_size = LEN_W'($urandom_range(65537, 1048576));
      end
    end else if (pick < 85) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[k];
      live_blocks.delete(k);
      r.operation = OP_FREE;
      r.block_offset = blk.offset;
      r.block_size = blk.length;
    end else if (pick < 90) begin
      r.operation = 1'($urandom());
      r.block_size = '0;
    end else if (pick < 96) begin
      // A free that was never allocated, possibly overlapping live data.
      base = $urandom_range(0, 32'h000F_FFFF);
      r.operation = OP_FREE;
      r.block_offset = ADDR_W'(base);
      if ($urandom_range(0, 1) == 0 && 32'h0010_0000 - base > 64) begin
        r.block_size = LEN_W'($urandom_range(1, 64));
      end else begin
        r.block_size = LEN_W'($urandom_range(1, 32'h0010_0000 - base));
      end
    end else begin
      base = $urandom_range(1, 32'h000F_FFFF);
      r.operation = OP_FREE;
      r.block_offset = ADDR_W'(base);
      r.block_size = LEN_W'($urandom_range(32'h0010_0001 - base, 32'h0010_0000));
    end
    return r;
  endfunction

  task automatic issue(ffla_req_t r, logic has_want, ffla_rsp_t want);
    ffla_rsp_t   got;
    live_block_t blk;
    logic [63:0] noise;
    start <= 1'b1;
    cmd <= r;
    do @(posedge clk); while (busy);
    got = apply_request(r);
    if (r.operation == OP_ALLOC && got.status == STATUS_OK) begin
      blk.offset = got.result_offset;
      blk.length = r.block_size;
      live_blocks.push_back(blk);
    end
    awaited_replies.push_back(has_want ? want : got);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      noise = {$urandom(), $urandom()};
      start <= 1'b0;
      cmd <= noise[$bits(ffla_req_t)-1:0];
      repeat ($urandom_range(1, 45)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    end
  endtask

  task automatic plan(logic op, int off, int size, int count, int stride, logic has_want,
                      int w_off, logic w_reused, logic [1:0] w_status);
    script_row_t row;
    row.req.operation = op;
    row.req.block_offset = ADDR_W'(off);
    row.req.block_size = LEN_W'(size);
    row.count = count;
    row.stride = stride;
    row.has_want = has_want;
    row.want.result_offset = ADDR_W'(w_off);
    row.want.reused_free = w_reused;
    row.want.status = w_status;
    script.push_back(row);
  endtask

  task automatic flag(string what, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    if (errors <= 40) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        if (errors <= 40) begin
          $display("%0t: result word with none expected, got %0h", $time, result);
        end
      end else begin
        if (result.result_offset !== awaited_replies[0].result_offset) begin
          flag("result_offset", awaited_replies[0].result_offset, result.result_offset);
        end
        if (result.reused_free !== awaited_replies[0].reused_free) begin
          flag("reused_free", awaited_replies[0].reused_free, result.reused_free);
        end
        if (result.status !== awaited_replies[0].status) begin
          flag("status", awaited_replies[0].status, result.status);
        end
        void'(awaited_replies.pop_front());
      end
    end
  end

  initial begin
    #2_000_000;
    $display("first_fit_free_list_allocator verification failed");
    $finish;
  end

  initial begin : stimulus
    ffla_req_t step;
    int        i;
    int        j;
    heap_top = '0;
    for (i = 0; i < ENTRIES; i++) begin
      hole_live[i] = 1'b0;
    end

    plan(OP_ALLOC, 0, 0, 1, 0, 1, 0, 0, STATUS_ZERO_SIZE);
    plan(OP_FREE, 'hFFFFF, 0, 1, 0, 1, 0, 0, STATUS_ZERO_SIZE);
    plan(OP_FREE, 1, 'h100000, 1, 0, 1, 0, 0, STATUS_HEAP_FULL);
    plan(OP_FREE, 'hFFFFF, 2, 1, 0, 1, 0, 0, STATUS_HEAP_FULL);
    plan(OP_FREE, 'h80000, 'h1FFFFF, 1, 0, 1, 0, 0, STATUS_HEAP_FULL);
    plan(OP_ALLOC, 0, 16, 1, 0, 1, 0, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 16, 1, 0, 1, 16, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 32, 1, 0, 1, 32, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 'h100000, 1, 0, 1, 0, 0, STATUS_HEAP_FULL);
    plan(OP_FREE, 16, 16, 1, 0, 1, 16, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 16, 1, 0, 1, 16, 1, STATUS_OK);
    plan(OP_FREE, 0, 16, 1, 0, 1, 0, 0, STATUS_OK);
    plan(OP_FREE, 16, 16, 1, 0, 1, 0, 0, STATUS_OK);
    plan(OP_FREE, 32, 32, 1, 0, 1, 0, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 8, 1, 0, 1, 0, 1, STATUS_OK);
    plan(OP_FREE, 0, 8, 1, 0, 1, 0, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 100, 1, 0, 1, 64, 0, STATUS_OK);
    plan(OP_FREE, 'hFFFFF, 1, 1, 0, 1, 'hFFFFF, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 1, 1, 0, 1, 0, 1, STATUS_OK);
    plan(OP_ALLOC, 0, 63, 1, 0, 1, 1, 1, STATUS_OK);
    plan(OP_ALLOC, 0, 1, 1, 0, 1, 'hFFFFF, 1, STATUS_OK);
    plan(OP_FREE, 200, 1, ENTRIES, 2, 0, 0, 0, STATUS_OK);
    plan(OP_FREE, 300, 1, 1, 0, 1, 0, 0, STATUS_TABLE_FULL);
    plan(OP_FREE, 201, 1, 1, 0, 1, 200, 0, STATUS_OK);
    plan(OP_FREE, 'h80000, 1, 1, 0, 1, 'h80000, 0, STATUS_OK);
    plan(OP_FREE, 'h80001, 1, 1, 0, 1, 'h80000, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 3, 1, 0, 1, 200, 1, STATUS_OK);
    plan(OP_FREE, 'h80000, 2, 1, 0, 0, 0, 0, STATUS_OK);
    plan(OP_FREE, 'h80002, 1, 1, 0, 0, 0, 0, STATUS_OK);
    plan(OP_ALLOC, 0, 3, 1, 0, 0, 0, 0, STATUS_OK);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < script.size(); i++) begin
      step = script[i].req;
      for (j = 0; j < script[i].count; j++) begin
        issue(step, script[i].has_want, script[i].want);
        step.block_offset = step.block_offset + ADDR_W'(script[i].stride);
      end
    end

    for (i = 0; i < 1500; i++) begin
      issue(draw_request(), 1'b0, '0);
    end

    // Ask for the rest of the heap up to the top of the address space, then for one byte more.
    if (heap_top < SPACE_BYTES) begin
      step.operation = OP_ALLOC;
      step.block_offset = '0;
      step.block_size = LEN_W'(SPACE_BYTES - heap_top);
      issue(step, 1'b0, '0);
    end
    step.operation = OP_ALLOC;
    step.block_size = LEN_W'(1);
    issue(step, 1'b0, '0);

    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("first_fit_free_list_allocator verification clean");
    end else begin
      $display("first_fit_free_list_allocator verification failed");
    end
    $finish;
  end

endmodule

// ===== first_fit_free_list_allocator.f =====
rtl/ffla_pkg.sv
rtl/ffla_ram.sv
rtl/first_fit_free_list_allocator.sv
test/tb.sv
